/* rtl/khb_pkg.sv */
`default_nettype none
package khb_pkg;

   localparam int KHB_MAX_KEY_BYTES = 64;

   localparam int CSR_IDX_W  = 8;
   localparam int HASH_W     = 64;
   localparam int BUCKET_W   = 63;
   localparam int KEY_LEN_W  = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MODE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BITS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED   = 8'd3;

   // hash_mode codes
   localparam logic HASH_FNV = 1'b0;
   localparam logic HASH_MUR = 1'b1;

   localparam logic [63:0] FNV32_BASIS  = 64'h0000_0000_811C_9DC5;
   localparam logic [63:0] FNV64_BASIS  = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] FNV32_FACTOR = 64'h0000_0000_0100_0193;
   localparam logic [63:0] FNV64_FACTOR = 64'h0000_0100_0000_01B3;
   localparam logic [63:0] MUR32_M      = 64'h0000_0000_5BD1_E995;
   localparam logic [63:0] MUR64_M      = 64'hC6A4_A793_5BD1_E995;
   localparam logic [63:0] LOW32_MASK   = 64'h0000_0000_FFFF_FFFF;

   localparam int MUR32_R  = 24;
   localparam int MUR64_R  = 47;
   localparam int MUR32_F1 = 13;
   localparam int MUR32_F2 = 15;

   typedef struct packed {
      logic                 hash_mode;
      logic [5:0]           bucket_bits;
      logic [KEY_LEN_W-1:0] key_length;
      logic [HASH_W-1:0]    hash_seed;
   } cfg_type;

   typedef struct packed {
      logic [7:0] key_byte;
      logic [2:0] slot;       // byte position inside the Murmur word
      logic       word_end;   // byte completes a Murmur word
      logic       last;       // last byte of the key
   } qent_type;

   typedef struct packed {
      logic              start;
      logic              wide;
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
   } mulreq_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] product;
   } mulrsp_type;

   // 64-bit variants above 31 bucket bits
   function automatic logic is_wide(input cfg_type c);
      return c.bucket_bits[5];
   endfunction

   // zero length counts as one byte, long keys clamp to the maximum
   function automatic logic [KEY_LEN_W-1:0] eff_len(input logic [KEY_LEN_W-1:0] kl);
      logic [KEY_LEN_W-1:0] n;
      if (kl == '0) begin
         n = KEY_LEN_W'(1);
      end else if (int'(kl) > KHB_MAX_KEY_BYTES) begin
         n = KEY_LEN_W'(KHB_MAX_KEY_BYTES);
      end else begin
         n = kl;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

/* rtl/khb_ifs.sv */
`default_nettype none
interface khb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_byte;
   modport source (output valid, output key_byte, input ready);
   modport sink (input valid, input key_byte, output ready);
endinterface

interface khb_rsp_if;
   logic        valid;
   logic        ready;
   logic [62:0] bucket_index;
   logic [63:0] full_hash;
   modport source (output valid, output bucket_index, output full_hash, input ready);
   modport sink (input valid, input bucket_index, input full_hash, output ready);
endinterface

interface khb_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/khb_front.sv */
`default_nettype none
module khb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire khb_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_byte,
   output logic                   in_ready,
   output logic                   out_valid,
   output khb_pkg::qent_type      out_entry,
   input  wire logic              out_ready
);
   import khb_pkg::*;

   logic [KEY_LEN_W-1:0] cnt_ff, cnt_in;
   logic [2:0]           slot_ff, slot_in;
   logic [KEY_LEN_W-1:0] len;
   logic                 last;
   logic                 word_end;
   logic                 accept;

   assign len      = eff_len(cfg.key_length);
   assign last     = (cnt_ff + KEY_LEN_W'(1)) == len;
   assign word_end = slot_ff == (is_wide(cfg) ? 3'd7 : 3'd3);
   assign accept   = in_valid && out_ready;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   always_comb begin
      out_entry.key_byte = in_byte;
      out_entry.slot     = slot_ff;
      out_entry.word_end = word_end;
      out_entry.last     = last;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (restart) begin
         cnt_in  = '0;
         slot_in = '0;
      end else if (accept) begin
         if (last) begin
            cnt_in  = '0;
            slot_in = '0;
         end else begin
            cnt_in  = cnt_ff + KEY_LEN_W'(1);
            slot_in = word_end ? 3'd0 : slot_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         slot_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/khb_queue.sv */
`default_nettype none
module khb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              flush,
   input  wire logic              in_valid,
   input  wire khb_pkg::qent_type in_entry,
   output logic                   in_ready,
   output logic                   out_valid,
   output khb_pkg::qent_type      out_entry,
   input  wire logic              out_ready
);
   import khb_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   qent_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != (PTR_W+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else begin
         if (push) begin
            wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_in = count_ff + (PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_in = count_ff - (PTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && !flush) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/khb_mul.sv */
`default_nettype none
module khb_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire khb_pkg::mulreq_type req,
   output khb_pkg::mulrsp_type      rsp
);
   import khb_pkg::*;

   // partial product order: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic [HASH_W-1:0] a_ff, b_ff, acc_ff;
   logic              wide_ff, busy_ff, done_ff;
   logic [1:0]        step_ff;
   logic [31:0]       x, y;
   logic [63:0]       p;
   logic              last_step;

   always_comb begin
      x = (step_ff == STEP_HL) ? a_ff[63:32] : a_ff[31:0];
      y = (step_ff == STEP_LH) ? b_ff[63:32] : b_ff[31:0];
      p = 64'(x) * 64'(y);
      last_step = !wide_ff || (step_ff == STEP_HL);
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff    <= req.a;
         b_ff    <= req.b;
         wide_ff <= req.wide;
      end
      if (busy_ff) begin
         if (step_ff == STEP_LL) begin
            acc_ff <= wide_ff ? p : {32'd0, p[31:0]};
         end else begin
            acc_ff[63:32] <= acc_ff[63:32] + p[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         done_ff <= busy_ff && last_step && !req.start;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_LL;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/khb_back.sv */
`default_nettype none
module khb_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                restart,
   input  wire khb_pkg::cfg_type    cfg,
   input  wire logic                in_valid,
   input  wire khb_pkg::qent_type   in_entry,
   output logic                     in_ready,
   output khb_pkg::mulreq_type      mul_req,
   input  wire khb_pkg::mulrsp_type mul_rsp,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [62:0]              rsp_bucket,
   output logic [63:0]              rsp_hash
);
   import khb_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_INIT_W, ST_IDLE, ST_FNV, ST_K1, ST_K2, ST_H,
      ST_FIN, ST_TAIL, ST_FMIX, ST_FEND, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [HASH_W-1:0] g_ff, g_in;
   logic [HASH_W-1:0] k_ff, k_in;
   logic [HASH_W-1:0] init_ff, init_in;
   logic              last_ff, last_in;
   logic              tail_ff, tail_in;
   mulreq_type        mreq_ff, mreq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [62:0]       rsp_bucket_ff, rsp_bucket_in;
   logic [63:0]       rsp_hash_ff, rsp_hash_in;

   logic              wide, mur;
   logic [HASH_W-1:0] m_const, fnv_prime, fnv_basis, mask, len64, gnew, p;

   assign wide      = is_wide(cfg);
   assign mur       = cfg.hash_mode == HASH_MUR;
   assign m_const   = wide ? MUR64_M : MUR32_M;
   assign fnv_prime = wide ? FNV64_FACTOR : FNV32_FACTOR;
   assign fnv_basis = wide ? FNV64_BASIS : FNV32_BASIS;
   assign mask      = ~({HASH_W{1'b1}} << cfg.bucket_bits);
   assign len64     = HASH_W'(eff_len(cfg.key_length));
   assign gnew      = g_ff | (HASH_W'(in_entry.key_byte) << {in_entry.slot, 3'b000});
   assign p         = mul_rsp.product;

   assign in_ready   = state_ff == ST_IDLE;
   assign mul_req    = mreq_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bucket = rsp_bucket_ff;
   assign rsp_hash   = rsp_hash_ff;

   always_comb begin
      state_in      = state_ff;
      h_in          = h_ff;
      g_in          = g_ff;
      k_in          = k_ff;
      init_in       = init_ff;
      last_in       = last_ff;
      tail_in       = tail_ff;
      mreq_in       = mreq_ff;
      mreq_in.start = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_hash_in   = rsp_hash_ff;

      case (state_ff)
         ST_INIT: begin
            // len * M64 for the wide Murmur seed mix
            mreq_in = '{start: 1'b1, wide: 1'b1, a: len64, b: MUR64_M};
            state_in = ST_INIT_W;
         end
         ST_INIT_W: begin
            if (mul_rsp.done) begin
               if (!mur) begin
                  init_in = fnv_basis;
               end else if (wide) begin
                  init_in = cfg.hash_seed ^ p;
               end else begin
                  init_in = (cfg.hash_seed ^ len64) & LOW32_MASK;
               end
               h_in     = init_in;
               g_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_valid) begin
               last_in = in_entry.last;
               tail_in = in_entry.last && !in_entry.word_end;
               if (!mur) begin
                  mreq_in = '{start: 1'b1, wide: wide,
                              a: h_ff ^ HASH_W'(in_entry.key_byte), b: fnv_prime};
                  state_in = ST_FNV;
               end else begin
                  g_in = gnew;
                  if (in_entry.word_end) begin
                     mreq_in  = '{start: 1'b1, wide: wide, a: gnew, b: m_const};
                     state_in = ST_K1;
                  end else begin
                     state_in = in_entry.last ? ST_FIN : ST_IDLE;
                  end
               end
            end
         end
         ST_FNV: begin
            if (mul_rsp.done) begin
               h_in     = p;
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_K1: begin
            if (mul_rsp.done) begin
               mreq_in = '{start: 1'b1, wide: wide,
                           a: wide ? (p ^ (p >> MUR64_R)) : (p ^ (p >> MUR32_R)),
                           b: m_const};
               state_in = ST_K2;
            end
         end
         ST_K2: begin
            if (mul_rsp.done) begin
               k_in = p;
               // wide: (h ^ k) * M, narrow: h * M then ^ k
               mreq_in  = '{start: 1'b1, wide: wide, a: wide ? (h_ff ^ p) : h_ff,
                            b: m_const};
               state_in = ST_H;
            end
         end
         ST_H: begin
            if (mul_rsp.done) begin
               h_in     = wide ? p : (p ^ k_ff);
               g_in     = '0;
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (!mur) begin
               state_in = ST_OUT;
            end else if (tail_ff) begin
               mreq_in  = '{start: 1'b1, wide: wide, a: h_ff ^ g_ff, b: m_const};
               state_in = ST_TAIL;
            end else begin
               state_in = ST_FMIX;
            end
         end
         ST_TAIL: begin
            if (mul_rsp.done) begin
               h_in     = p;
               state_in = ST_FMIX;
            end
         end
         ST_FMIX: begin
            mreq_in = '{start: 1'b1, wide: wide,
                        a: wide ? (h_ff ^ (h_ff >> MUR64_R)) : (h_ff ^ (h_ff >> MUR32_F1)),
                        b: m_const};
            state_in = ST_FEND;
         end
         ST_FEND: begin
            if (mul_rsp.done) begin
               h_in     = wide ? (p ^ (p >> MUR64_R)) : (p ^ (p >> MUR32_F2));
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = h_ff[62:0] & mask[62:0];
               rsp_hash_in   = h_ff;
               h_in          = init_ff;
               g_in          = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // register write abandons the key and recomputes the start value
      if (restart) begin
         state_in      = ST_INIT;
         mreq_in.start = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         mreq_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mreq_ff.start <= mreq_in.start;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mreq_ff.wide  <= mreq_in.wide;
      mreq_ff.a     <= mreq_in.a;
      mreq_ff.b     <= mreq_in.b;
      h_ff          <= h_in;
      g_ff          <= g_in;
      k_ff          <= k_in;
      init_ff       <= init_in;
      last_ff       <= last_in;
      tail_ff       <= tail_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_hash_ff   <= rsp_hash_in;
   end

endmodule
`default_nettype wire

/* rtl/key_hash_to_bucket.sv */
// A 64-bit multiply makes three 32x32 passes. FNV-1a multiplies once per byte.
// MurmurHash2 takes one byte per cycle while the back end is idle; a byte that completes a word
// holds the back end through the multiply sequence for that word.
// With the back end idle, the result comes soonest after the last byte is taken for FNV-1a 32,
// and latest for a word-ending last byte of Murmur 64.
// Reset and every register write restart the key and form the start value anew.
`default_nettype none
module key_hash_to_bucket (
   input  wire logic clock,
   input  wire logic reset,
   khb_req_if.sink   req_if,
   khb_rsp_if.source rsp_if,
   khb_csr_if.sink   csr_if
);
   import khb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic       f_valid, f_ready;
   qent_type   f_entry;
   logic       q_valid, q_ready;
   qent_type   q_entry;
   mulreq_type mul_req;
   mulrsp_type mul_rsp;
   logic [HASH_W-1:0] mask;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_if.index)
            CSR_HASH_MODE:   cfg_in.hash_mode   = csr_if.data[0];
            CSR_BUCKET_BITS: cfg_in.bucket_bits = csr_if.data[5:0];
            CSR_KEY_LENGTH:  cfg_in.key_length  = csr_if.data[KEY_LEN_W-1:0];
            CSR_HASH_SEED:   cfg_in.hash_seed   = csr_if.data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_mode   <= HASH_FNV;
         cfg_ff.bucket_bits <= 6'd5;
         cfg_ff.key_length  <= KEY_LEN_W'(4);
         cfg_ff.hash_seed   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   khb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_byte   (req_if.key_byte),
      .in_ready  (req_if.ready),
      .out_valid (f_valid),
      .out_entry (f_entry),
      .out_ready (f_ready)
   );

   khb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .flush     (csr_write),
      .in_valid  (f_valid),
      .in_entry  (f_entry),
      .in_ready  (f_ready),
      .out_valid (q_valid),
      .out_entry (q_entry),
      .out_ready (q_ready)
   );

   khb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   khb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .cfg        (cfg_ff),
      .in_valid   (q_valid),
      .in_entry   (q_entry),
      .in_ready   (q_ready),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_bucket (rsp_if.bucket_index),
      .rsp_hash   (rsp_if.full_hash)
   );

   assign mask = ~({HASH_W{1'b1}} << cfg_ff.bucket_bits);

   // a register write leaves nothing queued
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !q_valid)
      else $error("queue not empty after register write");

   // the bucket never has bits above the bucket count
   a_bucket_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.bucket_index & ~mask[62:0]) == '0))
      else $error("bucket index outside bucket count");

   // 32-bit variants come out zero-extended
   a_narrow_hash: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !is_wide(cfg_ff)) |-> (rsp_if.full_hash[63:32] == '0))
      else $error("32-bit hash has upper bits set");

endmodule
`default_nettype wire
